[sv/cpc_pkg.sv]
package cpc_pkg;

  // coordinate format, two's complement
  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned RAD_W      = COORD_BITS - 1;
  // coordinate difference
  localparam int unsigned DIFF_W     = COORD_BITS + 1;
  // squared radius
  localparam int unsigned R2_W       = 2 * RAD_W;
  // squared lengths, line values and projections (magnitude)
  localparam int unsigned SQ_W       = 2 * COORD_BITS + 1;
  // split of a squared-size value into two multiplier chunks
  localparam int unsigned LO_W       = (SQ_W + 1) / 2;
  localparam int unsigned HI_W       = SQ_W - LO_W;
  // threshold r^2 * len^2
  localparam int unsigned THR_W      = R2_W + SQ_W;
  // shared multiplier operands and product
  localparam int unsigned A_W        = SQ_W + 1;
  localparam int unsigned B_W        = LO_W + 1;
  localparam int unsigned P_W        = A_W + B_W;
  // accumulator, holds a squared line value with sign
  localparam int unsigned ACC_W      = 2 * SQ_W + 2;

  // stream packing
  localparam int unsigned IN_FIELDS_W = 4 * COORD_BITS + RAD_W;
  localparam int unsigned IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = 8;

  // sequencer lengths
  localparam int unsigned EDGE_STEPS   = 12;
  localparam int unsigned VTX_STEPS    = 2;
  localparam int unsigned DRAIN_CYCLES = 3;
  localparam int unsigned STEP_W       = $clog2(EDGE_STEPS);

  // operand pairs for the shared multiplier
  typedef enum logic [3:0] {
    OP_NONE,
    OP_DX,      // (cx - vx)^2
    OP_DY,      // (cy - vy)^2
    OP_R_R,     // r * r
    OP_A_U,     // a * (cx - p1x)
    OP_B_V,     // b * (cy - p1y)
    OP_A_A,     // a * a
    OP_B_B,     // b * b
    OP_NB_U,    // (p1x - p2x) * (cx - p1x)
    OP_A_V,     // a * (cy - p1y)
    OP_NB_U2,   // (p1x - p2x) * (cx - p2x)
    OP_A_V2,    // a * (cy - p2y)
    OP_R2_LO,   // r^2 * low chunk of len^2
    OP_R2_HI,   // r^2 * high chunk of len^2
    OP_LN_LO,   // |line| * low chunk of |line|
    OP_LN_HI    // |line| * high chunk of |line|
  } op_e;

  // what happens to a finished sum
  typedef enum logic [3:0] {
    DST_NONE,
    DST_R2,
    DST_VTX,
    DST_LINE,
    DST_LEN,
    DST_D1,
    DST_D2,
    DST_THR,
    DST_DEV
  } dest_e;

  typedef struct packed {
    logic  clr;   // start a new sum
    logic  sh;    // product weighted by the low chunk size
    dest_e dest;
  } pipe_ctl_t;

  localparam pipe_ctl_t PIPE_IDLE = '{clr: 1'b0, sh: 1'b0, dest: DST_NONE};

  typedef struct packed {
    op_e       op;
    pipe_ctl_t ctl;
  } edge_step_t;

  typedef struct packed {
    logic      accept;    // input transfer this cycle
    logic      first;     // accepted vertex opens a polygon
    op_e       op;
    logic      edge_b;    // closing edge (cur, first) instead of (prev, cur)
    pipe_ctl_t ctl;
    logic      out_load;  // move the hit flag into the output register
  } cmd_t;

  // micro-program of one edge test
  function automatic edge_step_t edge_step(input logic [STEP_W-1:0] idx);
    edge_step_t s;
    s.op  = OP_NONE;
    s.ctl = PIPE_IDLE;
    case (idx)
      4'd0:  begin s.op = OP_A_U;   s.ctl = '{clr: 1'b1, sh: 1'b0, dest: DST_NONE}; end
      4'd1:  begin s.op = OP_B_V;   s.ctl = '{clr: 1'b0, sh: 1'b0, dest: DST_LINE}; end
      4'd2:  begin s.op = OP_A_A;   s.ctl = '{clr: 1'b1, sh: 1'b0, dest: DST_NONE}; end
      4'd3:  begin s.op = OP_B_B;   s.ctl = '{clr: 1'b0, sh: 1'b0, dest: DST_LEN}; end
      4'd4:  begin s.op = OP_NB_U;  s.ctl = '{clr: 1'b1, sh: 1'b0, dest: DST_NONE}; end
      4'd5:  begin s.op = OP_A_V;   s.ctl = '{clr: 1'b0, sh: 1'b0, dest: DST_D1}; end
      4'd6:  begin s.op = OP_NB_U2; s.ctl = '{clr: 1'b1, sh: 1'b0, dest: DST_NONE}; end
      4'd7:  begin s.op = OP_A_V2;  s.ctl = '{clr: 1'b0, sh: 1'b0, dest: DST_D2}; end
      4'd8:  begin s.op = OP_R2_LO; s.ctl = '{clr: 1'b1, sh: 1'b0, dest: DST_NONE}; end
      4'd9:  begin s.op = OP_R2_HI; s.ctl = '{clr: 1'b0, sh: 1'b1, dest: DST_THR}; end
      4'd10: begin s.op = OP_LN_LO; s.ctl = '{clr: 1'b1, sh: 1'b0, dest: DST_NONE}; end
      4'd11: begin s.op = OP_LN_HI; s.ctl = '{clr: 1'b0, sh: 1'b1, dest: DST_DEV}; end
      default: begin
        s.op  = OP_NONE;
        s.ctl = PIPE_IDLE;
      end
    endcase
    return s;
  endfunction

endpackage

[sv/cpc_ctrl.sv]
module cpc_ctrl import cpc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_last_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    IDLE,
    RADIUS,
    EDGE_A,
    VERTEX,
    EDGE_B,
    DRAIN,
    DONE
  } state_e;

  state_e            state_q;
  logic [STEP_W-1:0] step_q;
  logic              in_poly_q;
  logic              last_q;
  logic              out_valid_q;

  logic       accept;
  logic       out_load;
  edge_step_t es;

  assign in_ready_o  = (state_q == IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && (state_q == IDLE);
  assign out_load    = (state_q == DONE) && (!out_valid_q || out_ready_i);
  assign es          = edge_step(step_q);

  always_comb begin
    cmd_o          = '0;
    cmd_o.accept   = accept;
    cmd_o.first    = !in_poly_q;
    cmd_o.edge_b   = (state_q == EDGE_B);
    cmd_o.out_load = out_load;
    cmd_o.op       = OP_NONE;
    cmd_o.ctl      = PIPE_IDLE;
    case (state_q)
      RADIUS: begin
        cmd_o.op  = OP_R_R;
        cmd_o.ctl = '{clr: 1'b1, sh: 1'b0, dest: DST_R2};
      end
      VERTEX: begin
        if (step_q == '0) begin
          cmd_o.op  = OP_DX;
          cmd_o.ctl = '{clr: 1'b1, sh: 1'b0, dest: DST_NONE};
        end else begin
          cmd_o.op  = OP_DY;
          cmd_o.ctl = '{clr: 1'b0, sh: 1'b0, dest: DST_VTX};
        end
      end
      EDGE_A, EDGE_B: begin
        cmd_o.op  = es.op;
        cmd_o.ctl = es.ctl;
      end
      default: begin
        cmd_o.op  = OP_NONE;
        cmd_o.ctl = PIPE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      step_q      <= '0;
      in_poly_q   <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // a new result may replace the one taken in the same cycle
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        IDLE: begin
          step_q <= '0;
          if (accept) begin
            last_q <= in_last_i;
            if (!in_poly_q) begin
              in_poly_q <= 1'b1;
              state_q   <= RADIUS;
            end else begin
              state_q <= EDGE_A;
            end
          end
        end
        RADIUS: begin
          step_q  <= '0;
          state_q <= VERTEX;
        end
        EDGE_A: begin
          if (step_q == STEP_W'(EDGE_STEPS - 1)) begin
            step_q  <= '0;
            state_q <= VERTEX;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        VERTEX: begin
          if (step_q == STEP_W'(VTX_STEPS - 1)) begin
            step_q  <= '0;
            state_q <= last_q ? EDGE_B : IDLE;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        EDGE_B: begin
          if (step_q == STEP_W'(EDGE_STEPS - 1)) begin
            step_q  <= '0;
            state_q <= DRAIN;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        DRAIN: begin
          if (step_q == STEP_W'(DRAIN_CYCLES - 1)) begin
            step_q  <= '0;
            state_q <= DONE;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        DONE: begin
          if (out_load) begin
            in_poly_q <= 1'b0;
            state_q   <= IDLE;
          end
        end
        default: begin
          state_q <= IDLE;
        end
      endcase
    end
  end

endmodule

[sv/cpc_datapath.sv]
module cpc_datapath import cpc_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cmd_t                         cmd_i,
  input  logic signed [COORD_BITS-1:0] vertex_x_i,
  input  logic signed [COORD_BITS-1:0] vertex_y_i,
  input  logic signed [COORD_BITS-1:0] center_x_i,
  input  logic signed [COORD_BITS-1:0] center_y_i,
  input  logic        [RAD_W-1:0]      circle_radius_i,
  output logic                         intersects_o
);

  function automatic logic signed [DIFF_W-1:0] sdiff(
    input logic signed [COORD_BITS-1:0] p,
    input logic signed [COORD_BITS-1:0] q
  );
    return DIFF_W'(p) - DIFF_W'(q);
  endfunction

  // polygon and circle state
  logic signed [COORD_BITS-1:0] first_x_q, first_y_q;
  logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q;
  logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q;
  logic signed [COORD_BITS-1:0] cen_x_q, cen_y_q;
  logic        [RAD_W-1:0]      rad_q;

  // intermediate results
  logic [R2_W-1:0]  r2_q;
  logic [SQ_W-1:0]  len2_q;
  logic [SQ_W-1:0]  line_q;
  logic [THR_W-1:0] thr_q;
  logic             d1_neg_q, d1_zero_q, proj_ok_q;
  logic             hit_q;
  logic             intersects_q;

  // multiply-accumulate pipe
  logic signed [A_W-1:0]   opa_d, opa_q;
  logic signed [B_W-1:0]   opb_d, opb_q;
  logic signed [P_W-1:0]   prod_q;
  logic signed [ACC_W-1:0] acc_d, acc_q;
  logic signed [ACC_W-1:0] pext, shifted, acc_abs;
  pipe_ctl_t               c1_q, c2_q, c3_q;

  logic signed [COORD_BITS-1:0] p1x, p1y, p2x, p2y;
  logic signed [DIFF_W-1:0]     dx, dy, ea, eb, enb, eu, ev, eu2, ev2;
  logic [SQ_W-1:0]              len_eff;
  logic                         d2_neg, d2_zero;
  logic                         vtx_in, dev_in;

  // edge end points
  assign p1x = cmd_i.edge_b ? cur_x_q   : prev_x_q;
  assign p1y = cmd_i.edge_b ? cur_y_q   : prev_y_q;
  assign p2x = cmd_i.edge_b ? first_x_q : cur_x_q;
  assign p2y = cmd_i.edge_b ? first_y_q : cur_y_q;

  assign dx  = sdiff(cen_x_q, cur_x_q);
  assign dy  = sdiff(cen_y_q, cur_y_q);
  assign ea  = sdiff(p1y, p2y);
  assign eb  = sdiff(p2x, p1x);
  assign enb = sdiff(p1x, p2x);
  assign eu  = sdiff(cen_x_q, p1x);
  assign ev  = sdiff(cen_y_q, p1y);
  assign eu2 = sdiff(cen_x_q, p2x);
  assign ev2 = sdiff(cen_y_q, p2y);

  // a degenerate edge scales the threshold by one
  assign len_eff = (len2_q == '0) ? SQ_W'(1) : len2_q;

  always_comb begin
    opa_d = '0;
    opb_d = '0;
    case (cmd_i.op)
      OP_DX:    begin opa_d = A_W'(dx);  opb_d = B_W'(dx);  end
      OP_DY:    begin opa_d = A_W'(dy);  opb_d = B_W'(dy);  end
      OP_R_R:   begin opa_d = A_W'(rad_q); opb_d = B_W'(rad_q); end
      OP_A_U:   begin opa_d = A_W'(ea);  opb_d = B_W'(eu);  end
      OP_B_V:   begin opa_d = A_W'(eb);  opb_d = B_W'(ev);  end
      OP_A_A:   begin opa_d = A_W'(ea);  opb_d = B_W'(ea);  end
      OP_B_B:   begin opa_d = A_W'(eb);  opb_d = B_W'(eb);  end
      OP_NB_U:  begin opa_d = A_W'(enb); opb_d = B_W'(eu);  end
      OP_A_V:   begin opa_d = A_W'(ea);  opb_d = B_W'(ev);  end
      OP_NB_U2: begin opa_d = A_W'(enb); opb_d = B_W'(eu2); end
      OP_A_V2:  begin opa_d = A_W'(ea);  opb_d = B_W'(ev2); end
      OP_R2_LO: begin
        opa_d = A_W'(r2_q);
        opb_d = B_W'(len_eff[LO_W-1:0]);
      end
      OP_R2_HI: begin
        opa_d = A_W'(r2_q);
        opb_d = B_W'(len_eff[SQ_W-1:LO_W]);
      end
      OP_LN_LO: begin
        opa_d = A_W'(line_q);
        opb_d = B_W'(line_q[LO_W-1:0]);
      end
      OP_LN_HI: begin
        opa_d = A_W'(line_q);
        opb_d = B_W'(line_q[SQ_W-1:LO_W]);
      end
      default: begin
        opa_d = '0;
        opb_d = '0;
      end
    endcase
  end

  // accumulate, high chunk products weighted by the low chunk size
  always_comb begin
    pext    = ACC_W'(prod_q);
    shifted = c2_q.sh ? (pext <<< LO_W) : pext;
    acc_d   = (c2_q.clr ? '0 : acc_q) + shifted;
  end

  assign acc_abs = acc_q[ACC_W-1] ? -acc_q : acc_q;
  assign d2_neg  = acc_q[ACC_W-1];
  assign d2_zero = (acc_q == '0);
  assign vtx_in  = (acc_q < $signed(ACC_W'(r2_q)));
  assign dev_in  = (acc_q < $signed(ACC_W'(thr_q))) && proj_ok_q;

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      prev_x_q <= cur_x_q;
      prev_y_q <= cur_y_q;
      cur_x_q  <= vertex_x_i;
      cur_y_q  <= vertex_y_i;
      if (cmd_i.first) begin
        first_x_q <= vertex_x_i;
        first_y_q <= vertex_y_i;
        cen_x_q   <= center_x_i;
        cen_y_q   <= center_y_i;
        rad_q     <= circle_radius_i;
      end
    end

    opa_q  <= opa_d;
    opb_q  <= opb_d;
    prod_q <= opa_q * opb_q;
    acc_q  <= acc_d;

    case (c3_q.dest)
      DST_R2:   r2_q   <= acc_q[R2_W-1:0];
      DST_LINE: line_q <= acc_abs[SQ_W-1:0];
      DST_LEN:  len2_q <= acc_q[SQ_W-1:0];
      DST_THR:  thr_q  <= acc_q[THR_W-1:0];
      DST_D1: begin
        d1_neg_q  <= d2_neg;
        d1_zero_q <= d2_zero;
      end
      DST_D2: begin
        // centre projects onto the edge, end points included
        proj_ok_q <= d1_zero_q || d2_zero || (d1_neg_q != d2_neg);
      end
      default: begin
      end
    endcase

    if (cmd_i.out_load) begin
      intersects_q <= hit_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q  <= PIPE_IDLE;
      c2_q  <= PIPE_IDLE;
      c3_q  <= PIPE_IDLE;
      hit_q <= 1'b0;
    end else begin
      c1_q <= cmd_i.ctl;
      c2_q <= c1_q;
      c3_q <= c2_q;
      if (cmd_i.out_load) begin
        hit_q <= 1'b0;
      end else if ((c3_q.dest == DST_VTX && vtx_in) ||
                   (c3_q.dest == DST_DEV && dev_in)) begin
        hit_q <= 1'b1;
      end
    end
  end

  assign intersects_o = intersects_q;

endmodule

[sv/circle_polygon_collision.sv]
// circle against polygon hit test. a polygon arrives as a run of vertex
// transfers closed by tlast; the first vertex of a run also carries the
// circle's centre and radius, which are ignored on later vertices. the
// polygon hits when a vertex lies strictly inside the circle or when an
// edge (the closing edge back to the first vertex included) passes strictly
// closer than the radius with the centre projecting onto it. one result
// transfer comes out per polygon, after its last vertex. all sums and
// products are exact; one shared 34 x 18 multiplier behind a four-stage
// multiply-accumulate pipe does the work, sequenced by a small controller.
// order per vertex: accept, test the edge ending in it, then its own
// distance to the centre; the first vertex squares the radius instead
// of an edge test, and the last adds the closing edge, a pipe drain
// and the result load. a finished result waits in its own output
// register, so the next polygon may start before it is taken.
module circle_polygon_collision import cpc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // vertex stream
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // vertex_x, vertex_y, center_x, center_y, circle_radius, zero fill
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // last_vertex
  input  logic                   s_axis_tlast_i,
  // result stream
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // intersects, zero fill
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  // tdata field offsets
  localparam int unsigned VX_LSB = 0;
  localparam int unsigned VY_LSB = VX_LSB + COORD_BITS;
  localparam int unsigned CX_LSB = VY_LSB + COORD_BITS;
  localparam int unsigned CY_LSB = CX_LSB + COORD_BITS;
  localparam int unsigned R_LSB  = CY_LSB + COORD_BITS;

  cmd_t cmd;
  logic intersects;

  logic signed [COORD_BITS-1:0] vertex_x, vertex_y, center_x, center_y;
  logic        [RAD_W-1:0]      circle_radius;

  // unpack the vertex transfer
  assign vertex_x      = s_axis_tdata_i[VX_LSB +: COORD_BITS];
  assign vertex_y      = s_axis_tdata_i[VY_LSB +: COORD_BITS];
  assign center_x      = s_axis_tdata_i[CX_LSB +: COORD_BITS];
  assign center_y      = s_axis_tdata_i[CY_LSB +: COORD_BITS];
  assign circle_radius = s_axis_tdata_i[R_LSB +: RAD_W];

  // sequencer: walks the multiply schedule of each vertex
  cpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_last_i   (s_axis_tlast_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  // operand selection, shared multiplier, accumulator and compares
  cpc_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .vertex_x_i      (vertex_x),
    .vertex_y_i      (vertex_y),
    .center_x_i      (center_x),
    .center_y_i      (center_y),
    .circle_radius_i (circle_radius),
    .intersects_o    (intersects)
  );

  // result transfer carries the hit flag in bit 0
  assign m_axis_tdata_o = {{(OUT_TDATA_W - 1){1'b0}}, intersects};

endmodule
